// ===== src/fsr_pkg.sv =====
// shared types and constants for the fresnel reflectance pipeline
package fsr_pkg;

  localparam int VECTOR_FRAC_BITS = 15;
  localparam int QF = 30;
  localparam int QW = QF + 1;
  localparam logic [QW-1:0] QONE = QW'(1) << QF;
  localparam int DOT_SHIFT = 2 * VECTOR_FRAC_BITS - QF;
  localparam int OUT_FRAC = 16;
  localparam int ROUND_SHIFT = QF - OUT_FRAC;
  localparam logic [16:0] OUT_ONE = 17'd65536;

  localparam int DIV_NW = 63;
  localparam int DIV_DW = 32;
  localparam int DIV_QW = 31;

  localparam int SQ_VW = 62;
  localparam int SQ_STAGES = 31;
  localparam int ROOT_W = 31;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic [15:0]        index_from;
    logic [15:0]        index_into;
    logic [16:0]        reflectivity;
  } fsr_req_t;

  typedef struct packed {
    logic [16:0] reflect_fraction;
    logic        total_internal;
  } fsr_rsp_t;

  typedef struct packed {
    logic          neg;
    logic          refract;
    logic          tir;
    logic          sum_zero;
    logic [QW-1:0] c;
    logic [QW-1:0] refl_q;
    logic [QW-1:0] r0;
  } fsr_side_t;

endpackage

// ===== src/fresnel_schlick_reflectance.sv =====
// fresnel_schlick_reflectance: Schlick reflectance with total internal reflection
// A request carries a normal, an incident direction (Q1.15), two refractive
// indices (Q2.14) and a reflectivity (Q0.16). Each request gives exactly one
// response: the reflected fraction in Q0.16 (65536 is 1.0) and a flag for
// total internal reflection.
// Both channels use valid/ready. The datapath is a 75-stage pipeline: four
// stages of dot product, cosine and refraction test, a 31-stage divider for
// the base reflectance and sin^2 of the refracted angle, one stage to square
// the ratio, a 31-stage square root, and eight stages for the fifth power,
// the Schlick term, the reflectivity blend and rounding. One request is taken
// every cycle while the receiver does not stall.
// The last stage is the output register. When the receiver stalls with a
// response waiting, the whole pipeline holds and req_ready drops; nothing is
// dropped or repeated. Reset clears all valid bits; the pipeline is empty
// and ready in the cycle after reset is released.
module fresnel_schlick_reflectance (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  fsr_pkg::fsr_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output fsr_pkg::fsr_rsp_t rsp
);

  localparam int QW = fsr_pkg::QW;
  localparam logic [fsr_pkg::ROUND_SHIFT-1:0] ROUND_ZERO = '0;

  typedef struct packed {
    logic          neg;
    logic          refract;
    logic [QW-1:0] c;
    logic [31:0]   n1sq;
    logic [31:0]   n2sq;
    logic [15:0]   d;
    logic [16:0]   sum;
    logic [QW-1:0] refl_q;
  } carry_t;

  typedef struct packed {
    logic          tir;
    logic          sat;
    logic [QW-1:0] refl_q;
    logic [QW-1:0] r0;
    logic [29:0]   x;
    logic [29:0]   x2;
    logic [29:0]   x4;
    logic [QW-1:0] x5;
    logic [QW-1:0] t;
    logic [QW-1:0] s;
    logic [QW-1:0] pf;
  } tail_t;

  logic en;

  // front stages
  logic               v1, v2, v3, v4;
  logic signed [31:0] p0, p1, p2;
  carry_t             c1, c2, c3, c4;
  logic [QW-1:0]      oc3;
  logic [62:0]        lhs4;

  logic signed [33:0] dot;
  logic [33:0]        mag;
  logic [16:0]        refl_clamp;
  logic [61:0]        csq;
  logic               tir_now;

  // divider and root phases
  logic                      vld_div [fsr_pkg::DIV_QW];
  fsr_pkg::fsr_side_t        side_div [fsr_pkg::DIV_QW];
  fsr_pkg::fsr_side_t        side_in;
  logic [fsr_pkg::DIV_QW-1:0] q_r0, q_sin;
  logic [61:0]               r0_prod;
  logic [QW-1:0]             sin2t;

  logic                      vp;
  fsr_pkg::fsr_side_t        side_p;
  logic [fsr_pkg::SQ_VW-1:0] rad_p;

  logic                       vld_sq [fsr_pkg::SQ_STAGES];
  fsr_pkg::fsr_side_t         side_sq [fsr_pkg::SQ_STAGES];
  logic [fsr_pkg::ROOT_W-1:0] root;

  // back stages
  logic                      va, vb, vc, vd, ve, vf, vg, vh;
  tail_t                     ta, tb, tc, td, te, tf, tg;
  fsr_pkg::fsr_side_t        side_last;
  logic [QW-1:0]             cc;
  logic [59:0]               x2_prod, x4_prod, x5_prod;
  logic [61:0]               t_prod, g_prod;
  logic [31:0]               s_sum, fin_sum;
  logic [QW-1:0]             fin;
  logic [31:0]               rnd;
  fsr_pkg::fsr_rsp_t         rsp_q;

  assign en        = !vh || rsp_ready;
  assign req_ready = en;
  assign rsp_valid = vh;
  assign rsp       = rsp_q;

  // ---------------- front ----------------
  assign refl_clamp = (req.reflectivity > fsr_pkg::OUT_ONE) ? fsr_pkg::OUT_ONE
                                                             : req.reflectivity;

  always_ff @(posedge clk) begin
    if (en) begin
      p0         <= req.normal_x * req.incident_x;
      p1         <= req.normal_y * req.incident_y;
      p2         <= req.normal_z * req.incident_z;
      c1.neg     <= 1'b0;
      c1.c       <= '0;
      c1.refract <= req.index_from > req.index_into;
      c1.n1sq    <= 32'(req.index_from) * 32'(req.index_from);
      c1.n2sq    <= 32'(req.index_into) * 32'(req.index_into);
      c1.d       <= (req.index_from > req.index_into) ? req.index_from - req.index_into
                                                      : req.index_into - req.index_from;
      c1.sum     <= 17'(req.index_from) + 17'(req.index_into);
      c1.refl_q  <= {refl_clamp, ROUND_ZERO};
    end
  end

  assign dot = 34'(p0) + 34'(p1) + 34'(p2);
  assign mag = dot[33] ? 34'(-dot) >> fsr_pkg::DOT_SHIFT : 34'(dot) >> fsr_pkg::DOT_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      c2     <= c1;
      // cosine is minus the dot product, kept as sign and magnitude
      c2.neg <= !dot[33] && (dot != '0);
      c2.c   <= (mag > 34'(fsr_pkg::QONE)) ? fsr_pkg::QONE : mag[QW-1:0];
    end
  end

  assign csq = 62'(c2.c) * 62'(c2.c);

  always_ff @(posedge clk) begin
    if (en) begin
      c3  <= c2;
      oc3 <= fsr_pkg::QONE - csq[60:30];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4   <= c3;
      lhs4 <= 63'(c3.n1sq) * 63'(oc3);
    end
  end

  // n1^2 (1 - c^2) > n2^2 means sin^2 of the refracted angle exceeds one
  assign tir_now = c4.refract && ((c4.n2sq == '0) || (lhs4 > {1'b0, c4.n2sq, 30'b0}));

  always_comb begin
    side_in          = '0;
    side_in.neg      = c4.neg;
    side_in.refract  = c4.refract;
    side_in.tir      = tir_now;
    side_in.sum_zero = (c4.sum == '0);
    side_in.c        = c4.c;
    side_in.refl_q   = c4.refl_q;
  end

  fsr_divider u_div_r0 (
    .clk      (clk),
    .en       (en),
    .dividend ({17'b0, c4.d, 30'b0}),
    .divisor  ({15'b0, c4.sum}),
    .quotient (q_r0)
  );

  fsr_divider u_div_sin (
    .clk      (clk),
    .en       (en),
    .dividend (lhs4),
    .divisor  (c4.n2sq),
    .quotient (q_sin)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_div[0] <= side_in;
      for (int i = 1; i < fsr_pkg::DIV_QW; i++) begin
        side_div[i] <= side_div[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsr_pkg::DIV_QW; i++) begin
        vld_div[i] <= 1'b0;
      end
    end else if (en) begin
      vld_div[0] <= v4;
      for (int i = 1; i < fsr_pkg::DIV_QW; i++) begin
        vld_div[i] <= vld_div[i-1];
      end
    end
  end

  // ---------------- base reflectance square and root input ----------------
  assign r0_prod = 62'(q_r0) * 62'(q_r0);
  assign sin2t   = (q_sin > fsr_pkg::QONE) ? fsr_pkg::QONE : q_sin;

  always_ff @(posedge clk) begin
    if (en) begin
      side_p    <= side_div[fsr_pkg::DIV_QW-1];
      side_p.r0 <= side_div[fsr_pkg::DIV_QW-1].sum_zero ? '0 : r0_prod[60:30];
      rad_p     <= {1'b0, fsr_pkg::QONE - sin2t, 30'b0};
    end
  end

  fsr_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (rad_p),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_sq[0] <= side_p;
      for (int i = 1; i < fsr_pkg::SQ_STAGES; i++) begin
        side_sq[i] <= side_sq[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsr_pkg::SQ_STAGES; i++) begin
        vld_sq[i] <= 1'b0;
      end
    end else if (en) begin
      vld_sq[0] <= vp;
      for (int i = 1; i < fsr_pkg::SQ_STAGES; i++) begin
        vld_sq[i] <= vld_sq[i-1];
      end
    end
  end

  // ---------------- back ----------------
  assign side_last = side_sq[fsr_pkg::SQ_STAGES-1];
  assign cc        = side_last.refract ? root : side_last.c;

  always_ff @(posedge clk) begin
    if (en) begin
      ta        <= '0;
      ta.tir    <= side_last.tir;
      ta.refl_q <= side_last.refl_q;
      ta.r0     <= side_last.r0;
      // 1 - c at or above one makes the fifth power saturate
      if ((side_last.neg && !side_last.refract) || (cc == '0)) begin
        ta.sat <= 1'b1;
        ta.x   <= '0;
      end else begin
        ta.sat <= 1'b0;
        ta.x   <= 30'(fsr_pkg::QONE - cc);
      end
    end
  end

  assign x2_prod = 60'(ta.x) * 60'(ta.x);
  assign x4_prod = 60'(tb.x2) * 60'(tb.x2);
  assign x5_prod = 60'(tc.x4) * 60'(tc.x);

  always_ff @(posedge clk) begin
    if (en) begin
      tb    <= ta;
      tb.x2 <= x2_prod[59:30];
      tc    <= tb;
      tc.x4 <= x4_prod[59:30];
      td    <= tc;
      td.x5 <= tc.sat ? fsr_pkg::QONE : {1'b0, x5_prod[59:30]};
    end
  end

  assign t_prod = 62'(fsr_pkg::QONE - td.r0) * 62'(td.x5);
  assign s_sum  = 32'(te.r0) + 32'(te.t);
  assign g_prod = 62'(fsr_pkg::QONE - tf.refl_q) * 62'(tf.s);

  always_ff @(posedge clk) begin
    if (en) begin
      te   <= td;
      te.t <= t_prod[60:30];
      tf   <= te;
      tf.s <= (s_sum > 32'(fsr_pkg::QONE)) ? fsr_pkg::QONE : s_sum[QW-1:0];
      tg   <= tf;
      tg.pf <= g_prod[60:30];
    end
  end

  assign fin_sum = 32'(tg.refl_q) + 32'(tg.pf);
  assign fin     = (fin_sum > 32'(fsr_pkg::QONE)) ? fsr_pkg::QONE : fin_sum[QW-1:0];
  assign rnd     = (32'(fin) + (32'(1) << (fsr_pkg::ROUND_SHIFT - 1)))
                   >> fsr_pkg::ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (tg.tir) begin
        rsp_q.reflect_fraction <= fsr_pkg::OUT_ONE;
        rsp_q.total_internal   <= 1'b1;
      end else begin
        rsp_q.reflect_fraction <= (rnd > 32'(fsr_pkg::OUT_ONE)) ? fsr_pkg::OUT_ONE
                                                                 : rnd[16:0];
        rsp_q.total_internal   <= 1'b0;
      end
    end
  end

  // valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vp <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      vp <= vld_div[fsr_pkg::DIV_QW-1];
      va <= vld_sq[fsr_pkg::SQ_STAGES-1];
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= vg;
    end
  end

`ifndef SYNTHESIS
  a_tir_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.total_internal |-> rsp.reflect_fraction == fsr_pkg::OUT_ONE)
    else $error("total internal reflection without full reflectance");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.reflect_fraction <= fsr_pkg::OUT_ONE)
    else $error("reflectance above one");

  a_tir_refract: assert property (@(posedge clk) disable iff (rst)
    vld_sq[fsr_pkg::SQ_STAGES-1] && side_last.tir |-> side_last.refract)
    else $error("total internal reflection flagged when n1 <= n2");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vg && vh && !rsp_ready |=> vg && vh)
    else $error("pipeline moved during a stall");
`endif

endmodule

// ===== src/fsr_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
module fsr_divider (
  input  logic                       clk,
  input  logic                       en,
  input  logic [fsr_pkg::DIV_NW-1:0] dividend,
  input  logic [fsr_pkg::DIV_DW-1:0] divisor,
  output logic [fsr_pkg::DIV_QW-1:0] quotient
);

  logic [fsr_pkg::DIV_NW-1:0] rem [fsr_pkg::DIV_QW];
  logic [fsr_pkg::DIV_DW-1:0] dvs [fsr_pkg::DIV_QW];
  logic [fsr_pkg::DIV_QW-1:0] quo [fsr_pkg::DIV_QW];

  for (genvar i = 0; i < fsr_pkg::DIV_QW; i++) begin : g_step
    logic [fsr_pkg::DIV_NW-1:0] r_in;
    logic [fsr_pkg::DIV_NW-1:0] trial;
    logic [fsr_pkg::DIV_DW-1:0] d_in;
    logic [fsr_pkg::DIV_QW-1:0] q_in;
    logic [fsr_pkg::DIV_QW-1:0] q_out;
    logic                       ge;

    if (i == 0) begin : g_first
      assign r_in = dividend;
      assign d_in = divisor;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign d_in = dvs[i-1];
      assign q_in = quo[i-1];
    end

    assign trial = fsr_pkg::DIV_NW'(d_in) << (fsr_pkg::DIV_QW - 1 - i);
    assign ge = r_in >= trial;

    always_comb begin
      q_out = q_in;
      q_out[fsr_pkg::DIV_QW-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? r_in - trial : r_in;
        dvs[i] <= d_in;
        quo[i] <= q_out;
      end
    end
  end

  assign quotient = quo[fsr_pkg::DIV_QW-1];

endmodule

// ===== src/fsr_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module fsr_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [fsr_pkg::SQ_VW-1:0]  radicand,
  output logic [fsr_pkg::ROOT_W-1:0] root
);

  logic [fsr_pkg::SQ_VW-1:0] val [fsr_pkg::SQ_STAGES];
  logic [fsr_pkg::SQ_VW-1:0] res [fsr_pkg::SQ_STAGES];

  for (genvar i = 0; i < fsr_pkg::SQ_STAGES; i++) begin : g_step
    logic [fsr_pkg::SQ_VW-1:0] v_in;
    logic [fsr_pkg::SQ_VW-1:0] r_in;
    logic [fsr_pkg::SQ_VW-1:0] bitw;
    logic [fsr_pkg::SQ_VW-1:0] trial;

    if (i == 0) begin : g_first
      assign v_in = radicand;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = val[i-1];
      assign r_in = res[i-1];
    end

    assign bitw  = fsr_pkg::SQ_VW'(1) << (2 * (fsr_pkg::SQ_STAGES - 1 - i));
    assign trial = r_in + bitw;

    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          val[i] <= v_in - trial;
          res[i] <= (r_in >> 1) + bitw;
        end else begin
          val[i] <= v_in;
          res[i] <= r_in >> 1;
        end
      end
    end
  end

  assign root = res[fsr_pkg::SQ_STAGES-1][fsr_pkg::ROOT_W-1:0];

endmodule
